// ===== design/drbl_pkg.sv =====
// ----------------------------------------------------------------------------
// drbl_pkg
// Types and constants of the DRAM row-buffer latency core.
// ----------------------------------------------------------------------------
`default_nettype none

package drbl_pkg;

  localparam int LINE_ADDR_BITS = 42;
  localparam int BANKS          = 16;
  localparam int BANK_W         = $clog2(BANKS);
  localparam int LSL_W          = 4;
  localparam int LSL_MAX        = (1 << LSL_W) - 1;
  localparam int LAT_W          = 8;
  localparam int CNT_W          = 64;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = LSL_W;

  typedef logic [LINE_ADDR_BITS-1:0] line_addr_t;
  typedef logic [LAT_W-1:0]          lat_t;
  typedef logic [CNT_W-1:0]          cnt_t;
  typedef logic [BANK_W-1:0]         bank_t;
  typedef logic [LSL_W-1:0]          lsl_t;
  typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]     cfg_data_t;

  localparam cfg_idx_t CFG_FIXED_MODE = 2'd0;
  localparam cfg_idx_t CFG_CLOSE_PAGE = 2'd1;
  localparam cfg_idx_t CFG_LINE_SIZE  = 2'd2;

  localparam lsl_t LSL_RESET = 4'd6;

  localparam lat_t LAT_ACT      = 8'd45;
  localparam lat_t LAT_CAS      = 8'd45;
  localparam lat_t LAT_PRE      = 8'd45;
  localparam lat_t LAT_BUS      = 8'd10;
  localparam lat_t LAT_FIXED    = 8'd100;
  localparam lat_t LAT_EMPTY    = LAT_ACT + LAT_CAS + LAT_BUS;
  localparam lat_t LAT_HIT      = LAT_CAS + LAT_BUS;
  localparam lat_t LAT_CONFLICT = LAT_PRE + LAT_ACT + LAT_CAS + LAT_BUS;

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } drbl_state_t;

endpackage

`default_nettype wire

// ===== design/drbl_in_if.sv =====
// ----------------------------------------------------------------------------
// drbl_in_if
// Access channel: one cache-line access per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface drbl_in_if;
  logic                                valid;
  logic                                ready;
  logic [drbl_pkg::LINE_ADDR_BITS-1:0] line_address;
  logic                                is_write;

  modport source (output valid, output line_address, output is_write, input ready);
  modport sink   (input valid, input line_address, input is_write, output ready);
endinterface

`default_nettype wire

// ===== design/drbl_out_if.sv =====
// ----------------------------------------------------------------------------
// drbl_out_if
// Result channel: latency of one access and the running totals.
// ----------------------------------------------------------------------------
`default_nettype none

interface drbl_out_if;
  logic                       valid;
  logic                       ready;
  logic [drbl_pkg::LAT_W-1:0] latency;
  logic [drbl_pkg::CNT_W-1:0] reads_total;
  logic [drbl_pkg::CNT_W-1:0] read_latency_total;
  logic [drbl_pkg::CNT_W-1:0] writes_total;
  logic [drbl_pkg::CNT_W-1:0] write_latency_total;

  modport source (output valid, output latency, output reads_total,
                  output read_latency_total, output writes_total,
                  output write_latency_total, input ready);
  modport sink   (input valid, input latency, input reads_total,
                  input read_latency_total, input writes_total,
                  input write_latency_total, output ready);
endinterface

`default_nettype wire

// ===== design/dram_row_buffer_latency_core.sv =====
// ----------------------------------------------------------------------------
// dram_row_buffer_latency_core
// DRAM open/close-page row-buffer latency model with running statistics.
//
// in_acc carries one access (line address, write flag) per transaction;
// out_res returns its latency and the read/write counts and
// latency sums including that access. cfg_* writes the mode registers
// (fixed latency, close page, line size); the user must write them only
// while the core is idle, the block itself does not enforce it. The open row
// of each bank sits in a 16-entry synchronous RAM read on acceptance; in the
// lookup state the core compares, and on commit writes back the new row and
// updates the counters and the output register. The core takes no new access
// until the lookup of the last one has committed, as the RAM read is followed
// by its write-back. The output register lets the next access be accepted
// while a result waits; if the receiver stalls, the lookup holds until the
// output register frees up. Reset clears the bank valid bits, counters,
// mode registers, state and output valid; no clearing pass runs over the RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module dram_row_buffer_latency_core #(
  parameter int ROW_BYTES_LOG2 = 10
) (
  input  logic                           clk,
  input  logic                           rst_n,
  drbl_in_if.sink                        in_acc,
  drbl_out_if.source                     out_res,
  input  logic                           cfg_we,
  input  logic [drbl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [drbl_pkg::CFG_DATA_W-1:0] cfg_data
);
  import drbl_pkg::*;

  localparam int BYTE_W = (LINE_ADDR_BITS + LSL_MAX > CNT_W) ? CNT_W
                                                             : LINE_ADDR_BITS + LSL_MAX;
  localparam int ROW_W  = BYTE_W - ROW_BYTES_LOG2 - BANK_W;

  typedef logic [ROW_W-1:0] row_t;

  // configuration
  logic fixed_r, close_r;
  lsl_t lsl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fixed_r <= 1'b0;
      close_r <= 1'b0;
      lsl_r   <= LSL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FIXED_MODE: fixed_r <= cfg_data[0];
        CFG_CLOSE_PAGE: close_r <= cfg_data[0];
        CFG_LINE_SIZE:  lsl_r   <= cfg_data;
        default:        ;
      endcase
    end
  end

  // FSM
  drbl_state_t state_r, state_nxt;
  logic        acc, commit, lookup;

  assign acc    = in_acc.valid && in_acc.ready;
  assign commit = lookup && (!out_res.valid || out_res.ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (acc)    state_nxt = ST_LOOKUP;
      ST_LOOKUP: if (commit) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_acc.ready = 1'b0;
    lookup       = 1'b0;
    case (state_r)
      ST_IDLE:   in_acc.ready = 1'b1;
      ST_LOOKUP: lookup       = 1'b1;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // address split
  logic [BYTE_W-1:0] byte_addr;
  bank_t             bank_in;
  row_t              row_in;

  assign byte_addr = BYTE_W'(in_acc.line_address) << lsl_r;
  assign bank_in   = byte_addr[ROW_BYTES_LOG2 +: BANK_W];
  assign row_in    = byte_addr[BYTE_W-1 -: ROW_W];

  bank_t bank_r;
  row_t  row_r;
  logic  wr_r;

  always_ff @(posedge clk) begin
    if (acc) begin
      bank_r <= bank_in;
      row_r  <= row_in;
      wr_r   <= in_acc.is_write;
    end
  end

  // open-row RAM
  row_t row_mem [BANKS];
  row_t rd_row_r;
  logic mem_we;

  always_ff @(posedge clk) begin
    if (acc) rd_row_r <= row_mem[bank_in];
  end

  always_ff @(posedge clk) begin
    if (mem_we) row_mem[bank_r] <= row_r;
  end

  logic [BANKS-1:0] open_vld_r;

  // latency decision
  lat_t lat;
  logic open_new;

  always_comb begin
    lat      = LAT_EMPTY;
    open_new = 1'b0;
    if (fixed_r) begin
      lat = LAT_FIXED;
    end else if (close_r) begin
      lat = LAT_EMPTY;
    end else if (!open_vld_r[bank_r]) begin
      lat      = LAT_EMPTY;
      open_new = 1'b1;
    end else if (rd_row_r == row_r) begin
      lat = LAT_HIT;
    end else begin
      lat      = LAT_CONFLICT;
      open_new = 1'b1;
    end
  end

  assign mem_we = commit && open_new;

  always_ff @(posedge clk) begin
    if (!rst_n)                                   open_vld_r         <= '0;
    else if (commit && !fixed_r && !close_r)      open_vld_r[bank_r] <= 1'b1;
  end

  // statistics
  cnt_t rcnt_r, rsum_r, wcnt_r, wsum_r;
  cnt_t rcnt_nxt, rsum_nxt, wcnt_nxt, wsum_nxt;

  always_comb begin
    rcnt_nxt = rcnt_r;
    rsum_nxt = rsum_r;
    wcnt_nxt = wcnt_r;
    wsum_nxt = wsum_r;
    if (wr_r) begin
      wcnt_nxt = wcnt_r + CNT_W'(1);
      wsum_nxt = wsum_r + CNT_W'(lat);
    end else begin
      rcnt_nxt = rcnt_r + CNT_W'(1);
      rsum_nxt = rsum_r + CNT_W'(lat);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rcnt_r <= '0;
      rsum_r <= '0;
      wcnt_r <= '0;
      wsum_r <= '0;
    end else if (commit) begin
      rcnt_r <= rcnt_nxt;
      rsum_r <= rsum_nxt;
      wcnt_r <= wcnt_nxt;
      wsum_r <= wsum_nxt;
    end
  end

  // output register
  logic out_vld_r;
  lat_t out_lat_r;
  cnt_t out_rcnt_r, out_rsum_r, out_wcnt_r, out_wsum_r;

  always_ff @(posedge clk) begin
    if (!rst_n)              out_vld_r <= 1'b0;
    else if (commit)         out_vld_r <= 1'b1;
    else if (out_res.ready)  out_vld_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_lat_r  <= lat;
      out_rcnt_r <= rcnt_nxt;
      out_rsum_r <= rsum_nxt;
      out_wcnt_r <= wcnt_nxt;
      out_wsum_r <= wsum_nxt;
    end
  end

  assign out_res.valid               = out_vld_r;
  assign out_res.latency             = out_lat_r;
  assign out_res.reads_total         = out_rcnt_r;
  assign out_res.read_latency_total  = out_rsum_r;
  assign out_res.writes_total        = out_wcnt_r;
  assign out_res.write_latency_total = out_wsum_r;

endmodule

`default_nettype wire

// ===== design/drbl_checker.sv =====
// ----------------------------------------------------------------------------
// drbl_checker
// Port-level checks on the row-buffer latency core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module drbl_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [drbl_pkg::LAT_W-1:0] latency,
  input wire logic [drbl_pkg::CNT_W-1:0] reads_total,
  input wire logic [drbl_pkg::CNT_W-1:0] writes_total
);
  import drbl_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(latency)
      && $stable(reads_total) && $stable(writes_total))
    else $error("stalled result changed");

  a_lat_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> latency == LAT_EMPTY || latency == LAT_HIT
      || latency == LAT_CONFLICT)
    else $error("illegal latency");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction accepted during lookup");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind dram_row_buffer_latency_core drbl_checker u_drbl_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_acc.valid),
  .in_ready     (in_acc.ready),
  .out_valid    (out_res.valid),
  .out_ready    (out_res.ready),
  .latency      (out_res.latency),
  .reads_total  (out_res.reads_total),
  .writes_total (out_res.writes_total)
);

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the DRAM row-buffer latency core.
//
// Accesses are queued up phase by phase and driven onto in_acc with random
// gaps. Each access taken by the core is costed on the spot against a local
// copy of the per-bank open-row table, mode registers and running totals, and
// the result is kept until out_res delivers its transaction. Mode registers
// change only between phases, once the core has drained.
// ----------------------------------------------------------------------------

module tb;
  import drbl_pkg::*;

  localparam int   ROW_LOG2      = 10;
  localparam lat_t COST_EMPTY    = 8'd100;
  localparam lat_t COST_HIT      = 8'd55;
  localparam lat_t COST_CONFLICT = 8'd145;
  localparam lat_t COST_FIXED    = 8'd100;
  localparam int   PHASE_ITEMS   = 145;
  localparam int   RANDOM_PHASES = 12;

  typedef struct packed {
    line_addr_t line;
    logic       wr;
  } access_t;

  typedef struct packed {
    lat_t latency;
    cnt_t reads;
    cnt_t read_lat;
    cnt_t writes;
    cnt_t write_lat;
  } stats_t;

  logic      clk;
  logic      rst_n;
  logic      cfg_we;
  cfg_idx_t  cfg_index;
  cfg_data_t cfg_data;

  drbl_in_if  acc_if ();
  drbl_out_if res_if ();

  dram_row_buffer_latency_core #(
    .ROW_BYTES_LOG2(ROW_LOG2)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_acc   (acc_if),
    .out_res  (res_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  access_t access_backlog[$];
  stats_t  expected_stats[$];

  // local copy of the core's state
  logic       mode_fixed;
  logic       mode_close;
  lsl_t       mode_lsl;
  logic [63:0] bank_row [BANKS];
  logic       bank_open [BANKS];
  cnt_t       n_reads, n_writes, sum_read_lat, sum_write_lat;

  access_t offered;
  logic    offering;
  int      send_gap;
  logic    send_burst;
  int      recv_stall;
  int      long_hold;
  int      hold_seen;
  logic    recv_burst;
  int      results_seen;
  int      mismatches;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic cost_access(input access_t a);
    logic [63:0] byte_addr;
    logic [63:0] upper;
    logic [63:0] row;
    bank_t       bank;
    stats_t      s;
    if (mode_fixed) begin
      s.latency = COST_FIXED;
    end else begin
      byte_addr = '0;
      byte_addr[LINE_ADDR_BITS-1:0] = a.line;
      byte_addr = byte_addr << mode_lsl;
      upper = byte_addr >> ROW_LOG2;
      bank  = upper[BANK_W-1:0];
      row   = upper >> BANK_W;
      if (mode_close) begin
        s.latency = COST_EMPTY;
      end else if (!bank_open[bank]) begin
        bank_open[bank] = 1'b1;
        bank_row[bank]  = row;
        s.latency = COST_EMPTY;
      end else if (bank_row[bank] == row) begin
        s.latency = COST_HIT;
      end else begin
        bank_row[bank] = row;
        s.latency = COST_CONFLICT;
      end
    end
    if (a.wr) begin
      n_writes      = n_writes + 1;
      sum_write_lat = sum_write_lat + cnt_t'(s.latency);
    end else begin
      n_reads      = n_reads + 1;
      sum_read_lat = sum_read_lat + cnt_t'(s.latency);
    end
    s.reads     = n_reads;
    s.read_lat  = sum_read_lat;
    s.writes    = n_writes;
    s.write_lat = sum_write_lat;
    expected_stats.push_back(s);
  endtask

  task automatic check_field(input string fname, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, exp_v, act_v);
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      acc_if.valid <= 1'b0;
      offering   = 1'b0;
      send_gap   = 0;
      send_burst = 1'b0;
    end else begin
      if (acc_if.valid && acc_if.ready) begin
        cost_access(offered);
        offering = 1'b0;
        if ($urandom_range(0, 31) == 0) send_burst = !send_burst;
        send_gap = send_burst ? 0 : $urandom_range(0, 8);
      end
      if (!offering) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (access_backlog.size() > 0) begin
          offered  = access_backlog.pop_front();
          offering = 1'b1;
          acc_if.line_address <= offered.line;
          acc_if.is_write     <= offered.wr;
        end
      end
      acc_if.valid <= offering;
    end
  end

  // long receiver hold, long enough to fill the core
  always @(posedge clk) begin
    if (!rst_n) begin
      long_hold <= 0;
      hold_seen <= 0;
    end else begin
      if (res_if.valid && res_if.ready) hold_seen <= hold_seen + 1;
      if (long_hold > 0) begin
        long_hold <= long_hold - 1;
      end else if (res_if.valid && res_if.ready &&
                   (hold_seen == 299 || hold_seen == 1099)) begin
        long_hold <= 60;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    stats_t s;
    if (!rst_n) begin
      res_if.ready <= 1'b0;
      recv_stall   = 0;
      recv_burst   = 1'b0;
      results_seen = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        results_seen++;
        if (expected_stats.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected transaction, latency %0d", $time, res_if.latency);
        end else begin
          s = expected_stats.pop_front();
          check_field("latency", 64'(s.latency), 64'(res_if.latency));
          check_field("reads_total", s.reads, res_if.reads_total);
          check_field("read_latency_total", s.read_lat, res_if.read_latency_total);
          check_field("writes_total", s.writes, res_if.writes_total);
          check_field("write_latency_total", s.write_lat, res_if.write_latency_total);
        end
        if ($urandom_range(0, 31) == 0) recv_burst = !recv_burst;
        recv_stall = recv_burst ? 0 : $urandom_range(0, 8);
      end
      if (long_hold > 0) begin
        res_if.ready <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  task automatic queue_access(input line_addr_t line, input logic wr);
    access_t a;
    a.line = line;
    a.wr   = wr;
    access_backlog.push_back(a);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_FIXED_MODE: mode_fixed = data[0];
      CFG_CLOSE_PAGE: mode_close = data[0];
      CFG_LINE_SIZE:  mode_lsl   = data;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (access_backlog.size() != 0 || offering || expected_stats.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic line_addr_t random_line();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[LINE_ADDR_BITS-1:0];
  endfunction

  initial begin
    line_addr_t ones;
    line_addr_t hot [8];
    line_addr_t v;
    line_addr_t t;
    int         ph;
    int         n;
    int         k;
    int         sel;

    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = CFG_FIXED_MODE;
    cfg_data            = '0;
    acc_if.valid        = 1'b0;
    acc_if.line_address = '0;
    acc_if.is_write     = 1'b0;
    res_if.ready        = 1'b0;
    offering            = 1'b0;
    mismatches          = 0;
    mode_fixed          = 1'b0;
    mode_close          = 1'b0;
    mode_lsl            = LSL_RESET;
    n_reads             = '0;
    n_writes            = '0;
    sum_read_lat        = '0;
    sum_write_lat       = '0;
    for (int b = 0; b < BANKS; b++) begin
      bank_row[b]  = '0;
      bank_open[b] = 1'b0;
    end
    ones = '1;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // open page, reset line size: empty, hit and conflict
    queue_access('0, 1'b0);
    queue_access('0, 1'b1);
    queue_access(42'h100, 1'b0);
    queue_access('0, 1'b1);
    queue_access(42'h10, 1'b0);
    queue_access(42'h11, 1'b1);
    queue_access(ones, 1'b0);
    queue_access(ones, 1'b1);
    queue_access(42'hF0, 1'b0);
    wait_drained();

    // fixed latency; upper data bits must be ignored
    write_reg(CFG_FIXED_MODE, 4'hF);
    queue_access('0, 1'b0);
    queue_access(ones, 1'b1);
    queue_access(42'h100, 1'b0);
    wait_drained();

    write_reg(CFG_FIXED_MODE, 4'hE);
    write_reg(CFG_CLOSE_PAGE, 4'h1);
    queue_access('0, 1'b1);
    queue_access(ones, 1'b0);
    wait_drained();

    // largest line size, byte address spans 57 bits
    write_reg(CFG_CLOSE_PAGE, 4'h2);
    write_reg(CFG_LINE_SIZE, 4'hF);
    queue_access('0, 1'b0);
    queue_access(ones, 1'b0);
    queue_access(ones, 1'b1);
    wait_drained();

    write_reg(CFG_LINE_SIZE, 4'h0);
    queue_access('0, 1'b0);
    queue_access(ones, 1'b1);
    queue_access(42'h3FF, 1'b0);
    wait_drained();

    write_reg(CFG_LINE_SIZE, 4'hA);
    queue_access(ones, 1'b0);
    queue_access(42'h1, 1'b1);
    wait_drained();

    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      write_reg(CFG_FIXED_MODE,
                {3'($urandom_range(0, 7)), 1'($urandom_range(0, 5) == 0)});
      write_reg(CFG_CLOSE_PAGE,
                {3'($urandom_range(0, 7)), 1'($urandom_range(0, 3) == 0)});
      if (ph == 0)      write_reg(CFG_LINE_SIZE, 4'h0);
      else if (ph == 1) write_reg(CFG_LINE_SIZE, 4'hA);
      else if (ph == 2) write_reg(CFG_LINE_SIZE, 4'hF);
      else              write_reg(CFG_LINE_SIZE, 4'($urandom_range(0, 15)));
      for (k = 0; k < 8; k++) hot[k] = random_line();
      for (n = 0; n < PHASE_ITEMS; n++) begin
        k   = $urandom_range(0, 7);
        sel = $urandom_range(0, 9);
        if (sel <= 4) begin
          v = hot[k];
        end else if (sel <= 6) begin
          t = '0;
          t[$urandom_range(0, LINE_ADDR_BITS - 1)] = 1'b1;
          v = hot[k] ^ t;
          hot[k] = v;
        end else if (sel == 7) begin
          t = '0;
          t[3:0] = 4'($urandom_range(0, 15));
          v = hot[k] ^ t;
        end else begin
          v = random_line();
        end
        queue_access(v, 1'($urandom_range(0, 1)));
      end
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
